### rtl/rbei_pkg.sv
`default_nettype none

package rbei_pkg;

  // Number format
  localparam int FRAC_BITS = 16;
  localparam int WORD_BITS = 32;
  localparam int DT_BITS   = FRAC_BITS + 1;
  localparam int PROD_BITS = 2 * WORD_BITS;
  localparam int MAG_BITS  = PROD_BITS - FRAC_BITS;

  // Fixed-point constants
  localparam longint unsigned ONE_FX       = 64'd1 << FRAC_BITS;
  localparam longint unsigned GRAVITY_FX   = ((64'd981 << FRAC_BITS) + 64'd50) / 64'd100;
  localparam longint unsigned DRAG_DEF_FX  = ((64'd1 << FRAC_BITS) + 64'd50) / 64'd100;

  localparam logic [WORD_BITS-1:0] ONE_WORD     = WORD_BITS'(ONE_FX);
  localparam logic [WORD_BITS-1:0] DRAG_DEFAULT = WORD_BITS'(DRAG_DEF_FX);
  localparam logic [WORD_BITS-1:0] NEG_GRAVITY  = WORD_BITS'(64'd0 - GRAVITY_FX);
  localparam logic [WORD_BITS-1:0] WORD_MAX     = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam logic [WORD_BITS-1:0] WORD_MIN     = {1'b1, {(WORD_BITS-1){1'b0}}};

  // Configuration register indexes
  localparam int CFG_IDX_BITS = 3;
  localparam logic [CFG_IDX_BITS-1:0] REG_MASS_RECIP = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_DRAG_RATE  = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_GRAVITY_ON = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_KINEMATIC  = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_SHAPE      = 3'd4;

  // Request commands
  typedef enum logic [1:0] {
    CMD_TICK    = 2'd0,
    CMD_FORCE   = 2'd1,
    CMD_IMPULSE = 2'd2,
    CMD_SET_POS = 2'd3
  } cmd_t;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_FACTOR,
    S_FACTOR_WB,
    S_GRAV,
    S_ACC_MUL,
    S_ACC_ADD,
    S_DRAG_MUL,
    S_DRAG_WB,
    S_POS_MUL,
    S_POS_ADD,
    S_CMD_MUL,
    S_CMD_ADD,
    S_DONE
  } state_t;

  typedef logic [WORD_BITS-1:0] word_t;

endpackage

`default_nettype wire

### rtl/rigid_body_euler_integrator.sv
`default_nettype none

// Rigid-body integrator for one body: keeps acceleration, velocity and
// position in signed Q16.16 and runs every product through one shared
// 32x32 multiplier whose product is registered, followed by one saturating
// adder. A tick computes the drag factor, adds gravity, then for each axis
// integrates velocity, applies drag and advances position (the last step
// only when a shape is attached). Force and impulse scale and add each
// axis in turn; set position and a kinematic tick go straight to the result.
// The block takes one request at a time; a finished result sits in an
// output register, so the next request can be accepted while it waits.
module rigid_body_euler_integrator (
  input  wire                                clk,
  input  wire                                rst,
  // configuration
  input  wire                                cfg_wr,
  input  wire  [rbei_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  wire  [rbei_pkg::WORD_BITS-1:0]     cfg_data,
  // request channel
  input  wire                                in_valid,
  output logic                               in_stall,
  input  wire  [1:0]                         cmd,
  input  wire  signed [rbei_pkg::WORD_BITS-1:0] vec_x,
  input  wire  signed [rbei_pkg::WORD_BITS-1:0] vec_y,
  input  wire  signed [rbei_pkg::WORD_BITS-1:0] vec_z,
  input  wire  [rbei_pkg::DT_BITS-1:0]       dt,
  // result channel
  output logic                               out_valid,
  input  wire                                out_stall,
  output logic signed [rbei_pkg::WORD_BITS-1:0] pos_x,
  output logic signed [rbei_pkg::WORD_BITS-1:0] pos_y,
  output logic signed [rbei_pkg::WORD_BITS-1:0] pos_z,
  output logic signed [rbei_pkg::WORD_BITS-1:0] vel_x,
  output logic signed [rbei_pkg::WORD_BITS-1:0] vel_y,
  output logic signed [rbei_pkg::WORD_BITS-1:0] vel_z,
  output logic                               pos_changed
);

  import rbei_pkg::*;

  // Configuration registers
  word_t mass_recip;
  word_t drag_rate;
  logic  gravity_on;
  logic  kinematic;
  logic  shape_attached;

  // Body state
  word_t accel [3];
  word_t vel   [3];
  word_t pos   [3];

  // Sequencer and captured request
  state_t                state;
  state_t                state_next;
  logic   [1:0]          axis;
  cmd_t                  cmd_q;
  word_t                 vec_q [3];
  logic   [DT_BITS-1:0]  dt_q;
  logic   [FRAC_BITS:0]  factor;
  logic                  moved;
  logic                  in_accept;
  logic                  out_load;
  logic                  last_axis;

  // Shared multiplier
  logic                  mul_signed;
  word_t                 mul_src;
  word_t                 mul_b;
  logic                  mul_neg;
  word_t                 mul_mag;
  logic [PROD_BITS-1:0]  prod;
  logic                  prod_neg;
  logic [MAG_BITS-1:0]   prod_mag;
  word_t                 scaled;

  // Shared adder
  word_t                 add_a;
  word_t                 add_b;
  logic [WORD_BITS:0]    add_sum;
  word_t                 sum_sat;

  // Write controls
  logic                  wr_accel;
  logic                  wr_vel;
  logic                  wr_pos;
  logic                  wr_use_sum;
  logic                  wr_grav;
  logic                  wr_factor;
  word_t                 wr_value;

  word_t                 im_eff;
  word_t                 drag_eff;
  logic [MAG_BITS-1:0]   loss;
  logic [FRAC_BITS:0]    factor_calc;

  assign in_accept = in_valid && !in_stall;
  assign in_stall  = (state != S_IDLE);
  assign out_load  = (state == S_DONE) && (!out_valid || !out_stall);
  assign last_axis = (axis == 2'd2);

  // Zero mass and drag registers fall back to their defaults
  assign im_eff   = (mass_recip == '0) ? ONE_WORD : mass_recip;
  assign drag_eff = (drag_rate == '0) ? DRAG_DEFAULT : drag_rate;

  // Next-state logic
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          case (cmd_t'(cmd))
            CMD_TICK:    state_next = kinematic ? S_DONE : S_FACTOR;
            CMD_FORCE:   state_next = S_CMD_MUL;
            CMD_IMPULSE: state_next = S_CMD_MUL;
            default:     state_next = S_DONE;
          endcase
        end
      end
      S_FACTOR:    state_next = S_FACTOR_WB;
      S_FACTOR_WB: state_next = S_GRAV;
      S_GRAV:      state_next = S_ACC_MUL;
      S_ACC_MUL:   state_next = S_ACC_ADD;
      S_ACC_ADD:   state_next = S_DRAG_MUL;
      S_DRAG_MUL:  state_next = S_DRAG_WB;
      S_DRAG_WB: begin
        if (moved) begin
          state_next = S_POS_MUL;
        end else begin
          state_next = last_axis ? S_DONE : S_ACC_MUL;
        end
      end
      S_POS_MUL:   state_next = S_POS_ADD;
      S_POS_ADD:   state_next = last_axis ? S_DONE : S_ACC_MUL;
      S_CMD_MUL:   state_next = S_CMD_ADD;
      S_CMD_ADD:   state_next = last_axis ? S_DONE : S_CMD_MUL;
      S_DONE:      state_next = out_load ? S_IDLE : S_DONE;
      default:     state_next = S_IDLE;
    endcase
  end

  // Datapath controls per state
  always_comb begin
    mul_signed = 1'b1;
    mul_src    = accel[axis];
    mul_b      = WORD_BITS'(dt_q);
    add_a      = vel[axis];
    add_b      = scaled;
    wr_accel   = 1'b0;
    wr_vel     = 1'b0;
    wr_pos     = 1'b0;
    wr_use_sum = 1'b1;
    wr_grav    = 1'b0;
    wr_factor  = 1'b0;
    case (state)
      S_FACTOR: begin
        mul_signed = 1'b0;
        mul_src    = drag_eff;
      end
      S_FACTOR_WB: begin
        wr_factor = 1'b1;
      end
      S_GRAV: begin
        add_a   = accel[1];
        add_b   = NEG_GRAVITY;
        wr_grav = gravity_on;
      end
      S_ACC_ADD: begin
        wr_vel = 1'b1;
      end
      S_DRAG_MUL: begin
        mul_src = vel[axis];
        mul_b   = WORD_BITS'(factor);
      end
      S_DRAG_WB: begin
        wr_vel     = 1'b1;
        wr_use_sum = 1'b0;
      end
      S_POS_MUL: begin
        mul_src = vel[axis];
      end
      S_POS_ADD: begin
        add_a  = pos[axis];
        wr_pos = 1'b1;
      end
      S_CMD_MUL: begin
        mul_src = vec_q[axis];
        mul_b   = im_eff;
      end
      S_CMD_ADD: begin
        if (cmd_q == CMD_FORCE) begin
          add_a    = accel[axis];
          wr_accel = 1'b1;
        end else begin
          wr_vel = 1'b1;
        end
      end
      default: begin
        wr_use_sum = 1'b1;
      end
    endcase
  end

  // Multiplier front end: sign and magnitude
  assign mul_neg = mul_signed && mul_src[WORD_BITS-1];
  assign mul_mag = mul_neg ? (~mul_src + 1'b1) : mul_src;

  // Scale registered product, apply sign, saturate
  assign prod_mag = prod[PROD_BITS-1:FRAC_BITS];
  always_comb begin
    if (prod_neg) begin
      if (prod_mag > MAG_BITS'(WORD_MIN)) begin
        scaled = WORD_MIN;
      end else begin
        scaled = ~prod_mag[WORD_BITS-1:0] + 1'b1;
      end
    end else begin
      if (prod_mag > MAG_BITS'(WORD_MAX)) begin
        scaled = WORD_MAX;
      end else begin
        scaled = prod_mag[WORD_BITS-1:0];
      end
    end
  end

  // Saturating add
  assign add_sum = {add_a[WORD_BITS-1], add_a} + {add_b[WORD_BITS-1], add_b};
  always_comb begin
    if (add_sum[WORD_BITS] != add_sum[WORD_BITS-1]) begin
      sum_sat = add_sum[WORD_BITS] ? WORD_MIN : WORD_MAX;
    end else begin
      sum_sat = add_sum[WORD_BITS-1:0];
    end
  end

  assign wr_value = wr_use_sum ? sum_sat : scaled;

  // Drag factor: one minus drag*dt, clamped at zero
  assign loss = prod_mag;
  always_comb begin
    if (loss[MAG_BITS-1:FRAC_BITS] != '0) begin
      factor_calc = '0;
    end else begin
      factor_calc = (FRAC_BITS+1)'(ONE_FX) - {1'b0, loss[FRAC_BITS-1:0]};
    end
  end

  // Product register
  always_ff @(posedge clk) begin
    prod     <= PROD_BITS'(mul_mag) * PROD_BITS'(mul_b);
    prod_neg <= mul_neg;
  end

  // Sequencer and request capture
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      axis  <= 2'd0;
      moved <= 1'b0;
    end else begin
      state <= state_next;
      if (in_accept) begin
        axis  <= 2'd0;
        moved <= (cmd_t'(cmd) == CMD_TICK) && !kinematic && shape_attached;
      end else if ((state == S_DRAG_WB && !moved) || state == S_POS_ADD ||
                   state == S_CMD_ADD) begin
        axis <= axis + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      cmd_q    <= cmd_t'(cmd);
      vec_q[0] <= vec_x;
      vec_q[1] <= vec_y;
      vec_q[2] <= vec_z;
      dt_q     <= dt;
    end
    if (wr_factor) begin
      factor <= factor_calc;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mass_recip     <= ONE_WORD;
      drag_rate      <= DRAG_DEFAULT;
      gravity_on     <= 1'b1;
      kinematic      <= 1'b0;
      shape_attached <= 1'b1;
    end else if (cfg_wr) begin
      case (cfg_index)
        REG_MASS_RECIP: mass_recip     <= cfg_data;
        REG_DRAG_RATE:  drag_rate      <= cfg_data;
        REG_GRAVITY_ON: gravity_on     <= cfg_data[0];
        REG_KINEMATIC:  kinematic      <= cfg_data[0];
        REG_SHAPE:      shape_attached <= cfg_data[0];
        default:        mass_recip     <= mass_recip;
      endcase
    end
  end

  // Body state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        accel[i] <= '0;
        vel[i]   <= '0;
        pos[i]   <= '0;
      end
    end else begin
      if (in_accept && cmd_t'(cmd) == CMD_SET_POS) begin
        pos[0] <= vec_x;
        pos[1] <= vec_y;
        pos[2] <= vec_z;
      end
      if (wr_grav) begin
        accel[1] <= sum_sat;
      end
      if (wr_accel) begin
        accel[axis] <= wr_value;
      end
      if (wr_vel) begin
        vel[axis] <= wr_value;
      end
      if (wr_pos) begin
        pos[axis] <= wr_value;
      end
      // a running tick clears each axis once its acceleration is used
      if (state == S_ACC_ADD) begin
        accel[axis] <= '0;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      pos_x       <= pos[0];
      pos_y       <= pos[1];
      pos_z       <= pos[2];
      vel_x       <= vel[0];
      vel_y       <= vel[1];
      vel_z       <= vel[2];
      pos_changed <= moved;
    end
  end

endmodule

`default_nettype wire

### rtl/rbei_checker.sv
`default_nettype none

module rbei_checker (
  input wire                               clk,
  input wire                               rst,
  input wire                               in_valid,
  input wire                               in_stall,
  input wire                               out_valid,
  input wire                               out_stall,
  input wire [rbei_pkg::WORD_BITS-1:0]     pos_x,
  input wire [rbei_pkg::WORD_BITS-1:0]     vel_y
);

  // Held result stays up
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // Held result keeps its payload
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(pos_x) && $stable(vel_y))
    else $error("result payload changed while stalled");

  // Every accepted request leaves the block busy in the following cycle
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("request accepted back to back");

  // A new result appears only as a request finishes
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without a request in progress");

endmodule

bind rigid_body_euler_integrator rbei_checker u_rbei_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .pos_x     (pos_x),
  .vel_y     (vel_y)
);

`default_nettype wire

### tb/sv/tb_top.sv
`timescale 1ns / 100ps

import rbei_pkg::*;

typedef longint unsigned ulong_t;

// Body state as seen on the result port after one request
typedef struct packed {
  word_t px;
  word_t py;
  word_t pz;
  word_t vx;
  word_t vy;
  word_t vz;
  logic  moved;
} body_state_t;

// Tracks acceleration, velocity and position of the body and queues the
// state expected after every accepted request.
class euler_tracker;
  longint      accel[3];
  longint      vel[3];
  longint      pos[3];
  ulong_t      mass_recip;
  ulong_t      drag_rate;
  bit          gravity_on;
  bit          kinematic;
  bit          shape_attached;
  body_state_t expected_states[$];
  int unsigned mismatches;

  function new();
    for (int i = 0; i < 3; i++) begin
      accel[i] = 0;
      vel[i]   = 0;
      pos[i]   = 0;
    end
    mass_recip     = ONE_FX;
    drag_rate      = DRAG_DEF_FX;
    gravity_on     = 1'b1;
    kinematic      = 1'b0;
    shape_attached = 1'b1;
    mismatches     = 0;
  endfunction

  function void write_reg(logic [CFG_IDX_BITS-1:0] idx, word_t data);
    case (idx)
      REG_MASS_RECIP: mass_recip = data;
      REG_DRAG_RATE:  drag_rate = data;
      REG_GRAVITY_ON: gravity_on = data[0];
      REG_KINEMATIC:  kinematic = data[0];
      REG_SHAPE:      shape_attached = data[0];
      default: ;
    endcase
  endfunction

  function longint clamp_word(longint v);
    longint hi_lim;
    longint lo_lim;
    hi_lim = (longint'(1) <<< (WORD_BITS - 1)) - 1;
    lo_lim = -hi_lim - 1;
    if (v > hi_lim) return hi_lim;
    if (v < lo_lim) return lo_lim;
    return v;
  endfunction

  // exact product of magnitudes, truncated, capped at 2^62
  function ulong_t scaled_mag(ulong_t a, ulong_t b);
    logic [127:0] prod;
    logic [127:0] cap;
    prod = {64'd0, a} * {64'd0, b};
    prod = prod >> FRAC_BITS;
    cap  = 128'd1 << 62;
    return (prod > cap) ? 64'(cap) : 64'(prod);
  endfunction

  function longint scale_signed(longint a, ulong_t b);
    bit     neg;
    ulong_t mag;
    ulong_t m;
    neg = a < 0;
    mag = neg ? ulong_t'(-a) : ulong_t'(a);
    m   = scaled_mag(mag, b);
    return clamp_word(neg ? -longint'(m) : longint'(m));
  endfunction

  function longint add_clamp(longint a, longint b);
    return clamp_word(a + b);
  endfunction

  function void integrate_request(cmd_t c, word_t x, word_t y, word_t z,
                                  logic [DT_BITS-1:0] dt_in);
    longint      v[3];
    ulong_t      im;
    ulong_t      drag;
    ulong_t      loss;
    ulong_t      factor;
    ulong_t      dt_val;
    bit          moved;
    body_state_t st;
    v[0]   = longint'(signed'(x));
    v[1]   = longint'(signed'(y));
    v[2]   = longint'(signed'(z));
    dt_val = dt_in;
    im     = (mass_recip != 0) ? mass_recip : ONE_FX;
    moved  = 1'b0;
    case (c)
      CMD_FORCE:
        for (int i = 0; i < 3; i++) accel[i] = add_clamp(accel[i], scale_signed(v[i], im));
      CMD_IMPULSE:
        for (int i = 0; i < 3; i++) vel[i] = add_clamp(vel[i], scale_signed(v[i], im));
      CMD_SET_POS:
        for (int i = 0; i < 3; i++) pos[i] = v[i];
      default: begin
        // tick: gravity, integrate, drag, advance, clear accel
        if (!kinematic) begin
          drag   = (drag_rate != 0) ? drag_rate : DRAG_DEF_FX;
          loss   = scaled_mag(drag, dt_val);
          factor = (loss >= ONE_FX) ? 0 : ONE_FX - loss;
          if (gravity_on) accel[1] = add_clamp(accel[1], -longint'(GRAVITY_FX));
          for (int i = 0; i < 3; i++) begin
            vel[i] = add_clamp(vel[i], scale_signed(accel[i], dt_val));
            vel[i] = scale_signed(vel[i], factor);
          end
          if (shape_attached) begin
            for (int i = 0; i < 3; i++) pos[i] = add_clamp(pos[i], scale_signed(vel[i], dt_val));
            moved = 1'b1;
          end
          for (int i = 0; i < 3; i++) accel[i] = 0;
        end
      end
    endcase
    st.px    = word_t'(pos[0]);
    st.py    = word_t'(pos[1]);
    st.pz    = word_t'(pos[2]);
    st.vx    = word_t'(vel[0]);
    st.vy    = word_t'(vel[1]);
    st.vz    = word_t'(vel[2]);
    st.moved = moved;
    expected_states.push_back(st);
  endfunction

  function int pending();
    return expected_states.size();
  endfunction

  function void compare_field(string name, word_t exp_v, word_t act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %h, got %h", name, exp_v, act_v);
      mismatches++;
    end
  endfunction

  function void check_state(word_t px, word_t py, word_t pz, word_t vx, word_t vy,
                            word_t vz, logic moved);
    body_state_t st;
    if (expected_states.size() == 0) begin
      $error("result with no request outstanding");
      mismatches++;
      return;
    end
    st = expected_states.pop_front();
    compare_field("pos_x", st.px, px);
    compare_field("pos_y", st.py, py);
    compare_field("pos_z", st.pz, pz);
    compare_field("vel_x", st.vx, vx);
    compare_field("vel_y", st.vy, vy);
    compare_field("vel_z", st.vz, vz);
    compare_field("pos_changed", word_t'(st.moved), word_t'(moved));
  endfunction
endclass

module tb_top;

  localparam int PHASE_ITEMS = 165;
  localparam int HOLD_CYCLES = 300;

  logic                    clk;
  logic                    rst;
  logic                    cfg_wr;
  logic [CFG_IDX_BITS-1:0] cfg_index;
  word_t                   cfg_data;
  logic                    in_valid;
  logic                    in_stall;
  cmd_t                    cmd;
  word_t                   vec_x;
  word_t                   vec_y;
  word_t                   vec_z;
  logic [DT_BITS-1:0]      dt;
  logic                    out_valid;
  logic                    out_stall;
  word_t                   pos_x;
  word_t                   pos_y;
  word_t                   pos_z;
  word_t                   vel_x;
  word_t                   vel_y;
  word_t                   vel_z;
  logic                    pos_changed;

  int hold_req;
  bit quiet;

  euler_tracker tracker = new();

  rigid_body_euler_integrator uut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr     (cfg_wr),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .cmd        (cmd),
    .vec_x      (vec_x),
    .vec_y      (vec_y),
    .vec_z      (vec_z),
    .dt         (dt),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .pos_z      (pos_z),
    .vel_x      (vel_x),
    .vel_y      (vel_y),
    .vel_z      (vel_z),
    .pos_changed(pos_changed)
  );

  // 20 ns clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // mostly short gaps, a few long
  function automatic int gap_len();
    if ($urandom_range(0, 99) < 90) return $urandom_range(1, 4);
    return $urandom_range(20, 50);
  endfunction

  function automatic word_t rand_component();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) begin
      case ($urandom_range(0, 4))
        0: return WORD_MAX;
        1: return WORD_MIN;
        2: return '0;
        3: return '1;
        default: return word_t'(1);
      endcase
    end
    if (r < 35) return $urandom();
    return word_t'(longint'($urandom_range(0, 2097152)) - 1048576);
  endfunction

  function automatic logic [DT_BITS-1:0] rand_step();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 20) return DT_BITS'(ONE_FX);
    if (r < 28) return DT_BITS'($urandom());
    if (r < 35) return '1;
    return DT_BITS'($urandom_range(1, 8192));
  endfunction

  // result side: random stalls, long hold-off on request
  initial begin
    int  hold_left;
    int  run_left;
    bit  stalled;
    hold_left = 0;
    run_left  = 0;
    stalled   = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (quiet) begin
        out_stall <= 1'b0;
      end else begin
        if (run_left == 0) begin
          stalled  = $urandom_range(0, 99) < 30;
          run_left = stalled ? gap_len() : $urandom_range(1, 12);
        end
        out_stall <= stalled;
        run_left--;
      end
    end
  end

  // result check
  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0)
      tracker.check_state(pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, pos_changed);
  end

  // present one request and hold it until accepted
  task automatic send_request(cmd_t c, word_t x, word_t y, word_t z,
                              logic [DT_BITS-1:0] d);
    @(negedge clk);
    cmd      <= c;
    vec_x    <= x;
    vec_y    <= y;
    vec_z    <= z;
    dt       <= d;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall !== 1'b0);
    tracker.integrate_request(c, x, y, z, d);
  endtask

  task automatic send_random();
    int   r;
    cmd_t c;
    r = $urandom_range(0, 99);
    c = (r < 35) ? CMD_TICK : (r < 60) ? CMD_FORCE : (r < 80) ? CMD_IMPULSE : CMD_SET_POS;
    send_request(c, rand_component(), rand_component(), rand_component(), rand_step());
  endtask

  // drop valid for a random gap, with junk on the payload
  task automatic idle_sender();
    int n;
    if (!quiet && $urandom_range(0, 99) < 35) begin
      n = gap_len();
      @(negedge clk);
      in_valid <= 1'b0;
      cmd      <= cmd_t'($urandom_range(0, 3));
      vec_x    <= $urandom();
      vec_y    <= $urandom();
      vec_z    <= $urandom();
      dt       <= DT_BITS'($urandom());
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task automatic run_phase(int count, int burst);
    for (int k = 0; k < count; k++) begin
      send_random();
      if (burst > 0) burst--;
      else idle_sender();
    end
  endtask

  // wait for every result to drain
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, word_t data);
    @(negedge clk);
    cfg_wr    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_wr    <= 1'b0;
    tracker.write_reg(idx, data);
  endtask

  // flag registers get random upper bits; also hit one unused index
  task automatic configure_body(word_t mass, word_t drag, bit grav, bit kin, bit shape);
    word_t d;
    write_reg(REG_MASS_RECIP, mass);
    write_reg(REG_DRAG_RATE, drag);
    d = $urandom();
    d[0] = grav;
    write_reg(REG_GRAVITY_ON, d);
    d = $urandom();
    d[0] = kin;
    write_reg(REG_KINEMATIC, d);
    d = $urandom();
    d[0] = shape;
    write_reg(REG_SHAPE, d);
    write_reg(REG_SHAPE + CFG_IDX_BITS'($urandom_range(1, 3)), $urandom());
  endtask

  // run limit
  initial begin
    #20000000;
    $display("Regression FAIL");
    $finish;
  end

  // main sequence
  initial begin
    rst       = 1'b1;
    cfg_wr    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    in_valid  = 1'b0;
    cmd       = CMD_TICK;
    vec_x     = '0;
    vec_y     = '0;
    vec_z     = '0;
    dt        = '0;
    hold_req  = 0;
    quiet     = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: extremes under reset settings
    send_request(CMD_SET_POS, WORD_MAX, WORD_MIN, '0, '0);
    send_request(CMD_TICK, '1, '1, '1, '0);
    send_request(CMD_TICK, '0, '0, '0, DT_BITS'(ONE_FX));
    send_request(CMD_SET_POS, '1, word_t'(1), '0, '1);
    send_request(CMD_FORCE, WORD_MAX, WORD_MIN, word_t'(1), '1);
    send_request(CMD_TICK, '0, '0, '0, DT_BITS'(ONE_FX));
    send_request(CMD_IMPULSE, WORD_MIN, WORD_MAX, '1, '0);
    send_request(CMD_TICK, '0, '0, '0, '1);
    send_request(CMD_FORCE, ONE_WORD, -ONE_WORD, ONE_WORD >> 1, '0);
    send_request(CMD_IMPULSE, '0, '0, '0, '1);
    send_request(CMD_TICK, '0, '0, '0, DT_BITS'(1024));
    send_request(CMD_FORCE, WORD_MAX, WORD_MAX, WORD_MAX, '0);
    send_request(CMD_FORCE, WORD_MAX, WORD_MAX, WORD_MAX, '0);
    send_request(CMD_TICK, '0, '0, '0, DT_BITS'(ONE_FX));
    send_request(CMD_IMPULSE, WORD_MIN, WORD_MIN, WORD_MIN, '0);
    send_request(CMD_IMPULSE, WORD_MIN, WORD_MIN, WORD_MIN, '0);
    send_request(CMD_TICK, '0, '0, '0, '1);
    send_request(CMD_SET_POS, '0, '0, '0, '0);
    send_request(CMD_TICK, '0, '0, '0, DT_BITS'(16384));
    wait_idle();

    // default settings, no idling on either side
    quiet = 1'b1;
    configure_body(ONE_WORD, DRAG_DEFAULT, 1'b1, 1'b0, 1'b1);
    run_phase(PHASE_ITEMS, 0);
    wait_idle();
    quiet = 1'b0;

    // zero inverse mass and zero drag fall back to defaults
    configure_body('0, '0, 1'b0, 1'b0, 1'b1);
    run_phase(PHASE_ITEMS, 0);
    wait_idle();

    // largest values, drag wipes velocity; receiver holds off meanwhile
    configure_body('1, '1, 1'b1, 1'b0, 1'b1);
    @(posedge clk);
    hold_req = HOLD_CYCLES;
    run_phase(PHASE_ITEMS, 24);
    wait_idle();

    // smallest nonzero values, no shape attached
    configure_body(word_t'(1), word_t'(1), 1'b1, 1'b0, 1'b0);
    run_phase(PHASE_ITEMS, 0);
    wait_idle();

    // kinematic body
    configure_body(ONE_WORD, DRAG_DEFAULT, 1'b1, 1'b1, 1'b1);
    run_phase(PHASE_ITEMS, 0);
    wait_idle();

    // random mass, light drag, random flags
    configure_body($urandom(), $urandom_range(0, 262144), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    run_phase(PHASE_ITEMS, 0);
    wait_idle();

    // heavy drag, no gravity
    configure_body(word_t'(16384), word_t'(3276800), 1'b0, 1'b0, 1'b1);
    run_phase(PHASE_ITEMS, 0);
    wait_idle();

    // moderate mass, random drag and flags
    configure_body($urandom_range(0, 262144), $urandom(), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    run_phase(PHASE_ITEMS, 0);
    wait_idle();

    repeat (40) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
